FILE: rtl/plns_pkg.sv
// Shared types, widths, codes and helpers of the polyline nearest station unit.
package plns_pkg;

  localparam int MAX_VERTICES_DEF = 32;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 34;   // multiplier operand
  localparam int PROD_W  = 68;   // multiplier product, squared sums
  localparam int SEG_W   = 35;   // signed differences and foot offsets
  localparam int U_W     = 33;   // projection parameter, Q0.32 with 1.0
  localparam int STA_W   = 48;
  localparam int DIST_W  = 33;
  localparam int LEN_W   = 34;   // stored segment length
  localparam int ROOT_W  = 36;
  localparam int RAD_W   = 72;
  localparam int SREM_W  = 40;
  localparam int STEP_W  = 6;

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 36;

  localparam logic [U_W-1:0]    U_ONE    = {1'b1, {(U_W-1){1'b0}}};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [STA_W-1:0]  STA_MAX  = {STA_W{1'b1}};
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(64'h8000_0000);

  // action codes
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // datapath operations
  localparam logic [4:0] OP_NOP          = 5'd0;
  localparam logic [4:0] OP_CAPTURE      = 5'd1;
  localparam logic [4:0] OP_CLEAR        = 5'd2;
  localparam logic [4:0] OP_APPEND       = 5'd3;
  localparam logic [4:0] OP_LOAD_APPEND  = 5'd4;
  localparam logic [4:0] OP_LOAD_A       = 5'd5;
  localparam logic [4:0] OP_LOAD_B       = 5'd6;
  localparam logic [4:0] OP_DIV_INIT     = 5'd7;
  localparam logic [4:0] OP_DIV_STEP     = 5'd8;
  localparam logic [4:0] OP_BEST         = 5'd9;
  localparam logic [4:0] OP_BEST_NEXT    = 5'd10;
  localparam logic [4:0] OP_SQ_INIT_LL   = 5'd11;
  localparam logic [4:0] OP_SQ_INIT_BEST = 5'd12;
  localparam logic [4:0] OP_SQ_STEP      = 5'd13;
  localparam logic [4:0] OP_OUT_RES      = 5'd14;
  localparam logic [4:0] OP_OUT_EMPTY    = 5'd15;

  // multiplier operand pairs
  localparam logic [3:0] MS_NONE = 4'd0;
  localparam logic [3:0] MS_LXLX = 4'd1;
  localparam logic [3:0] MS_LYLY = 4'd2;
  localparam logic [3:0] MS_DXLX = 4'd3;
  localparam logic [3:0] MS_DYLY = 4'd4;
  localparam logic [3:0] MS_LXU  = 4'd5;
  localparam logic [3:0] MS_LYU  = 4'd6;
  localparam logic [3:0] MS_EXEX = 4'd7;
  localparam logic [3:0] MS_EYEY = 4'd8;
  localparam logic [3:0] MS_LENU = 4'd9;
  localparam logic [3:0] MS_TTTT = 4'd10;

  // product destinations
  localparam logic [3:0] AC_NONE   = 4'd0;
  localparam logic [3:0] AC_LL_SET = 4'd1;
  localparam logic [3:0] AC_LL_ADD = 4'd2;
  localparam logic [3:0] AC_DOT1   = 4'd3;
  localparam logic [3:0] AC_DOT2   = 4'd4;
  localparam logic [3:0] AC_FX     = 4'd5;
  localparam logic [3:0] AC_FY     = 4'd6;
  localparam logic [3:0] AC_D2_SET = 4'd7;
  localparam logic [3:0] AC_D2_ADD = 4'd8;
  localparam logic [3:0] AC_PART   = 4'd9;
  localparam logic [3:0] AC_TT     = 4'd10;

  // memory read address select
  localparam logic [1:0] RD_PREV = 2'd0;
  localparam logic [1:0] RD_IDX  = 2'd1;
  localparam logic [1:0] RD_IDX1 = 2'd2;
  localparam logic [1:0] RD_BEST = 2'd3;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] mul;
    logic [3:0] acc;
    logic [1:0] rd;
  } plns_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       has_prev;
    logic       two_plus;
    logic       last_seg;
    logic       div_needed;
    logic       out_busy;
  } plns_stat_t;

  function automatic logic [MAG_W-1:0] mag(input logic [SEG_W-1:0] v);
    logic [SEG_W-1:0] n;
    n = -v;
    return v[SEG_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

FILE: rtl/polyline_nearest_station_unit.sv
// Top level of the polyline nearest station unit: ports, sequencer and datapath.
//
//   channel  | direction | tdata / tuser
//   in_      | slave     | tdata: point_x, point_y, tolerance; tuser: action
//   out_     | master    | tdata: station, distance, hit
//   cfg_     | write     | wall_thickness
//
// Append: the first vertex is stored directly, later ones after the 36-step root of the
// new segment. Query: each segment uses the shared 34x34 multiplier and, when u does not
// clamp, the 32-step divider; accept, dispatch, final root and result load frame them.
// A query on fewer than two vertices gives the empty result without segment work.
// Reset is synchronous; the vertex store needs no clearing.
// A result waits in its output register; the next beat is taken meanwhile.
module polyline_nearest_station_unit #(
  parameter int MAX_VERTICES = plns_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // point_x[31:0], point_y[63:32], tolerance[95:64]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // station[47:0], distance[80:48], hit[81], zero pad
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import plns_pkg::*;

  plns_cmd_t          cmd;
  plns_stat_t         stat;
  logic [STA_W-1:0]   station;
  logic [DIST_W-1:0]  distance;
  logic               hit;

  plns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plns_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_action    (in_tuser),
    .in_x         (in_tdata[31:0]),
    .in_y         (in_tdata[63:32]),
    .in_tol       (in_tdata[95:64]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_station  (station),
    .out_distance (distance),
    .out_hit      (hit)
  );

  assign out_tdata = {6'b0, hit, distance, station};

endmodule

FILE: rtl/plns_ctrl.sv
// Sequencer of the polyline nearest station unit: issues datapath commands.
module plns_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  plns_pkg::plns_stat_t stat,
  output plns_pkg::plns_cmd_t  cmd
);
  import plns_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_ALOAD  = 5'd2;
  localparam logic [4:0] S_QLOADA = 5'd3;
  localparam logic [4:0] S_QRD    = 5'd4;
  localparam logic [4:0] S_QLOADB = 5'd5;
  localparam logic [4:0] S_L1     = 5'd6;
  localparam logic [4:0] S_L2     = 5'd7;
  localparam logic [4:0] S_L3     = 5'd8;
  localparam logic [4:0] S_L4     = 5'd9;
  localparam logic [4:0] S_L5     = 5'd10;
  localparam logic [4:0] S_DIVC   = 5'd11;
  localparam logic [4:0] S_DIV    = 5'd12;
  localparam logic [4:0] S_F1     = 5'd13;
  localparam logic [4:0] S_F2     = 5'd14;
  localparam logic [4:0] S_F3     = 5'd15;
  localparam logic [4:0] S_E1     = 5'd16;
  localparam logic [4:0] S_E2     = 5'd17;
  localparam logic [4:0] S_E3     = 5'd18;
  localparam logic [4:0] S_CMP    = 5'd19;
  localparam logic [4:0] S_FIN1   = 5'd20;
  localparam logic [4:0] S_FIN2   = 5'd21;
  localparam logic [4:0] S_FIN3   = 5'd22;
  localparam logic [4:0] S_FIN4   = 5'd23;
  localparam logic [4:0] S_SQI    = 5'd24;
  localparam logic [4:0] S_SQ     = 5'd25;
  localparam logic [4:0] S_AWR    = 5'd26;
  localparam logic [4:0] S_OUT    = 5'd27;
  localparam logic [4:0] S_EMPTY  = 5'd28;

  logic [4:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              query_r, query_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    query_nxt = query_r;
    in_ready  = 1'b0;
    cmd       = '{op: OP_NOP, mul: MS_NONE, acc: AC_NONE, rd: RD_IDX};
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (stat.action)
          ACT_CLEAR: cmd.op = OP_CLEAR;
          ACT_APPEND: begin
            query_nxt = 1'b0;
            if (!stat.full) begin
              if (stat.has_prev) begin
                cmd.rd    = RD_PREV;
                state_nxt = S_ALOAD;
              end else begin
                state_nxt = S_AWR;
              end
            end
          end
          ACT_QUERY: begin
            query_nxt = 1'b1;
            state_nxt = stat.two_plus ? S_QLOADA : S_EMPTY;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ALOAD: begin
        cmd.op    = OP_LOAD_APPEND;
        state_nxt = S_L1;
      end
      S_QLOADA: begin
        cmd.op    = OP_LOAD_A;
        cmd.rd    = RD_IDX1;
        state_nxt = S_QLOADB;
      end
      S_QRD: begin
        cmd.rd    = RD_IDX1;
        state_nxt = S_QLOADB;
      end
      S_QLOADB: begin
        cmd.op    = OP_LOAD_B;
        state_nxt = S_L1;
      end
      S_L1: begin
        cmd.mul   = MS_LXLX;
        state_nxt = S_L2;
      end
      S_L2: begin
        cmd.mul   = MS_LYLY;
        cmd.acc   = AC_LL_SET;
        state_nxt = S_L3;
      end
      S_L3: begin
        cmd.acc   = AC_LL_ADD;
        cmd.mul   = MS_DXLX;
        state_nxt = query_r ? S_L4 : S_SQI;
      end
      S_L4: begin
        cmd.mul   = MS_DYLY;
        cmd.acc   = AC_DOT1;
        state_nxt = S_L5;
      end
      S_L5: begin
        cmd.acc   = AC_DOT2;
        state_nxt = S_DIVC;
      end
      S_DIVC: begin
        cmd.op    = OP_DIV_INIT;
        step_nxt  = '0;
        state_nxt = stat.div_needed ? S_DIV : S_F1;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = S_F1;
      end
      S_F1: begin
        cmd.mul   = MS_LXU;
        state_nxt = S_F2;
      end
      S_F2: begin
        cmd.mul   = MS_LYU;
        cmd.acc   = AC_FX;
        state_nxt = S_F3;
      end
      S_F3: begin
        cmd.acc   = AC_FY;
        state_nxt = S_E1;
      end
      S_E1: begin
        cmd.mul   = MS_EXEX;
        state_nxt = S_E2;
      end
      S_E2: begin
        cmd.mul   = MS_EYEY;
        cmd.acc   = AC_D2_SET;
        state_nxt = S_E3;
      end
      S_E3: begin
        cmd.acc   = AC_D2_ADD;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (stat.last_seg) begin
          cmd.op    = OP_BEST;
          state_nxt = S_FIN1;
        end else begin
          cmd.op    = OP_BEST_NEXT;
          state_nxt = S_QRD;
        end
      end
      S_FIN1: begin
        cmd.rd    = RD_BEST;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.rd    = RD_BEST;
        cmd.mul   = MS_LENU;
        state_nxt = S_FIN3;
      end
      S_FIN3: begin
        cmd.rd    = RD_BEST;
        cmd.acc   = AC_PART;
        cmd.mul   = MS_TTTT;
        state_nxt = S_FIN4;
      end
      S_FIN4: begin
        cmd.acc   = AC_TT;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.op    = query_r ? OP_SQ_INIT_BEST : OP_SQ_INIT_LL;
        step_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op   = OP_SQ_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = query_r ? S_OUT : S_AWR;
      end
      S_AWR: begin
        cmd.op    = OP_APPEND;
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        // hold until the result slot frees up
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT_RES;
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      query_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      query_r <= query_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(SQRT_STEPS))
    else $error("iteration counter out of range");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVC && stat.div_needed) |-> ##33 (state_r == S_F1))
    else $error("division did not take its fixed step count");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid) |=> (state_r == S_DISP))
    else $error("accepted beat not dispatched");
`endif

endmodule

FILE: rtl/plns_dp.sv
// Datapath of the polyline nearest station unit: vertex store, multiplier, divider, root.
module plns_dp #(
  parameter int MAX_VERTICES = plns_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  plns_pkg::plns_cmd_t        cmd,
  output plns_pkg::plns_stat_t       stat,
  input  logic [1:0]                 in_action,
  input  logic [plns_pkg::COORD_W-1:0] in_x,
  input  logic [plns_pkg::COORD_W-1:0] in_y,
  input  logic [plns_pkg::COORD_W-1:0] in_tol,
  input  logic                       cfg_wr_en,
  input  logic [plns_pkg::COORD_W-1:0] cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [plns_pkg::STA_W-1:0]  out_station,
  output logic [plns_pkg::DIST_W-1:0] out_distance,
  output logic                       out_hit
);
  import plns_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic [COORD_W-1:0] mem_y [MAX_VERTICES];
  logic [STA_W-1:0]   mem_st [MAX_VERTICES];
  logic [LEN_W-1:0]   mem_len [MAX_VERTICES];

  logic [COORD_W-1:0] rd_x_r, rd_y_r;
  logic [STA_W-1:0]   rd_st_r;
  logic [LEN_W-1:0]   rd_len_r;
  logic [AW-1:0]      rd_addr;

  logic [1:0]         action_r;
  logic [COORD_W-1:0] px_r, py_r, tol_r, wt_r;
  logic [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic [CW-1:0]      cnt_r;
  logic [STA_W-1:0]   run_r;
  logic [AW-1:0]      idx_r, best_idx_r;

  logic [PROD_W-1:0]  prod_r, ll_r, pos_r, neg_r, d2_r, best_r, tt2_r, rem_r;
  logic               neg_sel_r;
  logic [U_W-1:0]     uq_r, best_uq_r;
  logic [SEG_W-1:0]   fx_r, fy_r;
  logic [STA_W-1:0]   station_r;

  logic [RAD_W-1:0]   sq_x_r;
  logic [SREM_W-1:0]  sq_rem_r;
  logic [ROOT_W-1:0]  sq_root_r;

  logic               out_valid_r;
  logic [STA_W-1:0]   out_station_r;
  logic [DIST_W-1:0]  out_distance_r;
  logic               out_hit_r;

  // differences, sign extended
  logic [SEG_W-1:0] lx, ly, dx, dy, ex, ey;
  logic [MAG_W-1:0] op_a, op_b;
  logic [MAG_W-1:0] tt;
  logic [PROD_W-1:0] diff_pn, fm_w, rem_sh;
  logic [SREM_W-1:0] sq_rem_sh, sq_trial;
  logic [STA_W:0]    part_sum, run_sum;
  logic [CW-1:0]     cnt_m1;
  logic [CW:0]       idx_p2;
  logic              better, load_out;

  assign lx = SEG_W'($signed(bx_r)) - SEG_W'($signed(ax_r));
  assign ly = SEG_W'($signed(by_r)) - SEG_W'($signed(ay_r));
  assign dx = SEG_W'($signed(px_r)) - SEG_W'($signed(ax_r));
  assign dy = SEG_W'($signed(py_r)) - SEG_W'($signed(ay_r));
  assign ex = dx - fx_r;
  assign ey = dy - fy_r;
  assign tt = MAG_W'(wt_r) + {1'b0, tol_r, 1'b0};

  assign cnt_m1 = cnt_r - 1'b1;
  assign idx_p2 = (CW+1)'(idx_r) + (CW+1)'(2);

  always_comb begin
    case (cmd.rd)
      RD_PREV: rd_addr = cnt_m1[AW-1:0];
      RD_IDX:  rd_addr = idx_r;
      RD_IDX1: rd_addr = idx_r + 1'b1;
      RD_BEST: rd_addr = best_idx_r;
      default: rd_addr = idx_r;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.mul)
      MS_LXLX: begin op_a = mag(lx); op_b = mag(lx); end
      MS_LYLY: begin op_a = mag(ly); op_b = mag(ly); end
      MS_DXLX: begin op_a = mag(dx); op_b = mag(lx); end
      MS_DYLY: begin op_a = mag(dy); op_b = mag(ly); end
      MS_LXU:  begin op_a = mag(lx); op_b = MAG_W'(uq_r); end
      MS_LYU:  begin op_a = mag(ly); op_b = MAG_W'(uq_r); end
      MS_EXEX: begin op_a = mag(ex); op_b = mag(ex); end
      MS_EYEY: begin op_a = mag(ey); op_b = mag(ey); end
      MS_LENU: begin op_a = MAG_W'(rd_len_r); op_b = MAG_W'(best_uq_r); end
      MS_TTTT: begin op_a = tt; op_b = tt; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign diff_pn   = pos_r - neg_r;
  assign fm_w      = prod_r + HALF_LSB;
  assign rem_sh    = {rem_r[PROD_W-2:0], 1'b0};
  assign sq_rem_sh = {sq_rem_r[SREM_W-3:0], sq_x_r[RAD_W-1 -: 2]};
  assign sq_trial  = {2'b00, sq_root_r, 2'b01};
  assign part_sum  = (STA_W+1)'(rd_st_r) + (STA_W+1)'(prod_r[PROD_W-1:32]);
  assign run_sum   = (STA_W+1)'(run_r) + (STA_W+1)'(sq_root_r);
  assign better    = (idx_r == '0) || (d2_r < best_r);
  assign load_out  = (cmd.op == OP_OUT_RES) || (cmd.op == OP_OUT_EMPTY);

  // vertex store, registered read
  always_ff @(posedge clk) begin
    rd_x_r   <= mem_x[rd_addr];
    rd_y_r   <= mem_y[rd_addr];
    rd_st_r  <= mem_st[rd_addr];
    rd_len_r <= mem_len[rd_addr];
    if (cmd.op == OP_APPEND && cnt_r != CW'(MAX_VERTICES)) begin
      mem_x[cnt_r[AW-1:0]] <= px_r;
      mem_y[cnt_r[AW-1:0]] <= py_r;
      if (cnt_r != '0) begin
        mem_st[cnt_m1[AW-1:0]]  <= run_r;
        mem_len[cnt_m1[AW-1:0]] <= sq_root_r[LEN_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a * op_b);
    if (cmd.op == OP_CAPTURE) begin
      action_r <= in_action;
      px_r     <= in_x;
      py_r     <= in_y;
      tol_r    <= in_tol;
      idx_r    <= '0;
    end
    if (cmd.op == OP_LOAD_APPEND) begin
      ax_r <= rd_x_r;
      ay_r <= rd_y_r;
      bx_r <= px_r;
      by_r <= py_r;
    end
    if (cmd.op == OP_LOAD_A) begin
      ax_r <= rd_x_r;
      ay_r <= rd_y_r;
    end
    if (cmd.op == OP_LOAD_B) begin
      bx_r <= rd_x_r;
      by_r <= rd_y_r;
    end
    case (cmd.acc)
      AC_LL_SET: ll_r <= prod_r;
      AC_LL_ADD: ll_r <= ll_r + prod_r;
      AC_DOT1: begin
        neg_sel_r <= 1'b0;
        if (dy[SEG_W-1] != ly[SEG_W-1]) neg_sel_r <= 1'b1;
        if (dx[SEG_W-1] != lx[SEG_W-1]) begin
          neg_r <= prod_r;
          pos_r <= '0;
        end else begin
          pos_r <= prod_r;
          neg_r <= '0;
        end
      end
      AC_DOT2: begin
        if (neg_sel_r) neg_r <= neg_r + prod_r;
        else           pos_r <= pos_r + prod_r;
      end
      AC_FX: fx_r <= lx[SEG_W-1] ? -SEG_W'(fm_w[PROD_W-1:32]) : SEG_W'(fm_w[PROD_W-1:32]);
      AC_FY: fy_r <= ly[SEG_W-1] ? -SEG_W'(fm_w[PROD_W-1:32]) : SEG_W'(fm_w[PROD_W-1:32]);
      AC_D2_SET: d2_r <= prod_r;
      AC_D2_ADD: d2_r <= d2_r + prod_r;
      AC_PART: station_r <= part_sum[STA_W] ? STA_MAX : part_sum[STA_W-1:0];
      AC_TT: tt2_r <= prod_r;
      default: ;
    endcase
    case (cmd.op)
      OP_DIV_INIT: begin
        rem_r <= diff_pn;
        uq_r  <= '0;
        if (ll_r != '0 && pos_r > neg_r && diff_pn >= ll_r) uq_r <= U_ONE;
      end
      OP_DIV_STEP: begin
        // restoring step: shift, trial subtract, set quotient bit
        if (rem_sh >= ll_r) begin
          rem_r <= rem_sh - ll_r;
          uq_r  <= {uq_r[U_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          uq_r  <= {uq_r[U_W-2:0], 1'b0};
        end
      end
      OP_BEST, OP_BEST_NEXT: begin
        if (better) begin
          best_r     <= d2_r;
          best_uq_r  <= uq_r;
          best_idx_r <= idx_r;
        end
        if (cmd.op == OP_BEST_NEXT) begin
          ax_r  <= bx_r;
          ay_r  <= by_r;
          idx_r <= idx_r + 1'b1;
        end
      end
      OP_SQ_INIT_LL, OP_SQ_INIT_BEST: begin
        sq_x_r    <= RAD_W'((cmd.op == OP_SQ_INIT_LL) ? ll_r : best_r);
        sq_rem_r  <= '0;
        sq_root_r <= '0;
      end
      OP_SQ_STEP: begin
        sq_x_r <= {sq_x_r[RAD_W-3:0], 2'b00};
        if (sq_rem_sh >= sq_trial) begin
          sq_rem_r  <= sq_rem_sh - sq_trial;
          sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_rem_sh;
          sq_root_r <= {sq_root_r[ROOT_W-2:0], 1'b0};
        end
      end
      OP_OUT_RES: begin
        out_station_r  <= station_r;
        out_distance_r <= (sq_root_r > ROOT_W'(DIST_MAX)) ? DIST_MAX
                                                          : sq_root_r[DIST_W-1:0];
        out_hit_r      <= ({best_r, 2'b00} <= {2'b00, tt2_r});
      end
      OP_OUT_EMPTY: begin
        out_station_r  <= '0;
        out_distance_r <= DIST_MAX;
        out_hit_r      <= 1'b0;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      run_r       <= '0;
      wt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) wt_r <= cfg_wr_data;
      if (cmd.op == OP_CLEAR) begin
        cnt_r <= '0;
        run_r <= '0;
      end
      if (cmd.op == OP_APPEND && cnt_r != CW'(MAX_VERTICES)) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r != '0) run_r <= run_sum[STA_W] ? STA_MAX : run_sum[STA_W-1:0];
      end
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign stat.action     = action_r;
  assign stat.full       = (cnt_r == CW'(MAX_VERTICES));
  assign stat.has_prev   = (cnt_r != '0);
  assign stat.two_plus   = (cnt_r > CW'(1));
  assign stat.last_seg   = (idx_p2 >= (CW+1)'(cnt_r));
  assign stat.div_needed = (ll_r != '0) && (pos_r > neg_r) && (diff_pn < ll_r);
  assign stat.out_busy   = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_station  = out_station_r;
  assign out_distance = out_distance_r;
  assign out_hit      = out_hit_r;

`ifndef NO_ASSERTIONS
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");
  a_uq_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_BEST || cmd.op == OP_BEST_NEXT) |-> (uq_r <= U_ONE))
    else $error("projection parameter above one");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten while held");
  a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule

FILE: verif/plns_checker.sv
// Checker of the polyline nearest station unit: predicts each query result and compares it.
module plns_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [87:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          errors,
  output int          pending,
  output int          hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import plns_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;

  typedef struct {
    logic [STA_W-1:0]  station;
    logic [DIST_W-1:0] distance;
    logic              hit;
  } pick_t;

  longint            vert_x[NV];
  longint            vert_y[NV];
  logic [STA_W-1:0]  seg_station[NV];
  int                n_vert;
  logic [STA_W-1:0]  arc_len;
  logic [31:0]       wall;
  pick_t             pick_q[$];

  function automatic logic [127:0] umag(input longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [127:0] sq_sum(input longint a, input longint b);
    return umag(a) * umag(a) + umag(b) * umag(b);
  endfunction

  function automatic logic [127:0] int_root(input logic [127:0] x);
    logic [127:0] r, t;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [STA_W-1:0] add_sat(input logic [127:0] a, input logic [127:0] b);
    logic [127:0] s;
    s = a + b;
    return s > 128'(STA_MAX) ? STA_MAX : s[STA_W-1:0];
  endfunction

  function automatic pick_t nearest(input longint px, input longint py, input logic [31:0] tol);
    pick_t res;
    logic [127:0] best, ll, d2, uq, fm, part, tt;
    logic signed [127:0] dot;
    longint ax, ay, lx, ly, dx, dy, fx, fy;
    res.station = '0;
    res.distance = DIST_MAX;
    res.hit = 1'b0;
    best = 0;
    if (n_vert < 2) return res;
    for (int i = 0; i + 1 < n_vert; i++) begin
      ax = vert_x[i];
      ay = vert_y[i];
      lx = vert_x[i+1] - ax;
      ly = vert_y[i+1] - ay;
      dx = px - ax;
      dy = py - ay;
      ll = sq_sum(lx, ly);
      dot = 128'(signed'(dx)) * 128'(signed'(lx)) + 128'(signed'(dy)) * 128'(signed'(ly));
      uq = 0;
      if (ll != 0 && dot > 0) begin
        if (128'(dot) >= ll) uq = 128'd1 << 32;
        else uq = (128'(dot) << 32) / ll;
      end
      fm = (umag(lx) * uq + 128'h8000_0000) >> 32;
      fx = lx < 0 ? -longint'(fm) : longint'(fm);
      fm = (umag(ly) * uq + 128'h8000_0000) >> 32;
      fy = ly < 0 ? -longint'(fm) : longint'(fm);
      d2 = sq_sum(dx - fx, dy - fy);
      // first segment wins a tie
      if (i == 0 || d2 < best) begin
        part = int_root(ll) * uq;
        best = d2;
        res.station = add_sat(128'(seg_station[i]), part >> 32);
      end
    end
    part = int_root(best);
    res.distance = part > 128'(DIST_MAX) ? DIST_MAX : part[DIST_W-1:0];
    tt = 128'(wall) + 2 * 128'(tol);
    res.hit = (best << 2) <= tt * tt;
    return res;
  endfunction

  assign pending = pick_q.size();

  always @(posedge clk) begin
    longint px, py;
    pick_t got, want;
    if (!rst_n) begin
      n_vert <= 0;
      arc_len <= '0;
      wall <= '0;
      pick_q.delete();
      errors <= 0;
      hits <= 0;
    end else begin
      if (cfg_wr_en) wall <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        px = longint'(signed'(in_tdata[31:0]));
        py = longint'(signed'(in_tdata[63:32]));
        case (in_tuser)
          ACT_CLEAR: begin
            n_vert <= 0;
            arc_len <= '0;
          end
          ACT_APPEND: begin
            if (n_vert < NV) begin
              if (n_vert > 0) begin
                seg_station[n_vert-1] <= arc_len;
                arc_len <= add_sat(128'(arc_len),
                  int_root(sq_sum(px - vert_x[n_vert-1], py - vert_y[n_vert-1])));
              end
              vert_x[n_vert] <= px;
              vert_y[n_vert] <= py;
              n_vert <= n_vert + 1;
            end
          end
          ACT_QUERY: begin
            // queue the prediction at the tail
            pick_q = {pick_q, nearest(px, py, in_tdata[95:64])};
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.station = out_tdata[47:0];
        got.distance = out_tdata[80:48];
        got.hit = out_tdata[81];
        if (pick_q.size() == 0) begin
          $display("%0t: result beat with none expected: station %h distance %h hit %b",
                   $time, got.station, got.distance, got.hit);
          errors <= errors + 1;
        end else begin
          want = pick_q.pop_front();
          if (got.station !== want.station || got.distance !== want.distance ||
              got.hit !== want.hit) begin
            $display("%0t: mismatch expected station %h distance %h hit %b, got %h %h %b",
                     $time, want.station, want.distance, want.hit,
                     got.station, got.distance, got.hit);
            errors <= errors + 1;
          end
          if (want.hit) hits <= hits + 1;
        end
      end
    end
  end
endmodule

FILE: verif/tb_top.sv
// Testbench top of the polyline nearest station unit: stimulus, configuration phases, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import plns_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  int          errors, pending, hits;
  int          n_query, n_append, n_other;
  bit          gaps_on;

  polyline_nearest_station_unit dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_wr_en, .cfg_wr_data
  );

  plns_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .cfg_wr_en, .cfg_wr_data,
    .errors, .pending, .hits
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("[polyline_nearest_station_unit] ERROR");
    $finish;
  end

  // receiver stalls about 30 percent of the time while gaps are on
  always @(posedge clk) out_tready <= !gaps_on || ($urandom_range(99) >= 30);

  task automatic beat(input logic [1:0] act, input logic [31:0] x, input logic [31:0] y,
                      input logic [31:0] tol);
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {tol, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act == ACT_QUERY) n_query++;
    else if (act == ACT_APPEND) n_append++;
    else n_other++;
    if (gaps_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic set_wall(input logic [31:0] w);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // an append leaves no result; give it time to finish
    repeat (150) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2, 3: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($signed($urandom_range(80000)) - 40000);
    endcase
  endfunction

  function automatic logic [31:0] tol_val();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'hffff_ffff;
      2: return 0;
      default: return $urandom_range(20000);
    endcase
  endfunction

  initial begin
    int items, nv, nq;
    logic [31:0] x0, y0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_APPEND;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    gaps_on = 1'b0;
    n_query = 0;
    n_append = 0;
    n_other = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and single vertex, extremes, degenerate segment, tie, clear, unused code
    beat(ACT_QUERY, 0, 0, 0);
    beat(ACT_APPEND, 32'h8000_0000, 32'h8000_0000, 0);
    beat(ACT_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    beat(ACT_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    beat(ACT_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    beat(ACT_QUERY, 32'h7fff_ffff, 32'h8000_0000, 0);
    beat(ACT_QUERY, 0, 0, 0);
    beat(ACT_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    beat(ACT_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    beat(ACT_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    beat(ACT_QUERY, 5, 5, 0);
    beat(ACT_APPEND, 0, 0, 0);
    beat(ACT_APPEND, 32'd8192, 0, 0);
    beat(ACT_APPEND, 0, 0, 0);
    beat(ACT_QUERY, 32'd4096, 32'd4096, 32'd4096);
    beat(ACT_QUERY, 32'hffff_f000, 32'd100, 0);
    beat(2'd3, 32'h1234_5678, 32'h9abc_def0, 32'hffff_ffff);
    beat(ACT_QUERY, 32'd4096, 32'hffff_f000, 32'd2048);
    set_wall(32'hffff_ffff);
    beat(ACT_QUERY, 32'd4096, 32'd40960, 0);
    set_wall(32'd8192);
    beat(ACT_QUERY, 32'd4096, 32'd4096, 0);
    beat(ACT_QUERY, 32'd4096, 32'd4097, 0);

    // random phases of polylines with queries, gaps on except in every sixth phase
    items = 0;
    for (int ph = 0; items < 580; ph++) begin
      gaps_on = (ph % 6) != 3;
      if (ph % 4 == 0) begin
        case ($urandom_range(3))
          0: set_wall(0);
          1: set_wall(32'hffff_ffff);
          2: set_wall($urandom());
          default: set_wall($urandom_range(40000));
        endcase
      end
      if ($urandom_range(9) == 0) begin
        beat($urandom_range(1) ? 2'd3 : ACT_QUERY, coord(), coord(), tol_val());
        items++;
      end
      beat(ACT_CLEAR, $urandom(), $urandom(), $urandom());
      nv = ($urandom_range(11) == 0) ? $urandom_range(34, 20) : $urandom_range(6, 0);
      x0 = coord();
      y0 = coord();
      for (int k = 0; k < nv; k++) begin
        // mostly a walk near the previous vertex, sometimes a repeat
        if ($urandom_range(7) != 0) begin
          x0 = ($urandom_range(4) == 0) ? coord() : x0 + 32'($signed($urandom_range(60000)) - 30000);
          y0 = ($urandom_range(4) == 0) ? coord() : y0 + 32'($signed($urandom_range(60000)) - 30000);
        end
        beat(ACT_APPEND, x0, y0, $urandom());
      end
      nq = nv > 12 ? $urandom_range(3, 1) : $urandom_range(8, 1);
      for (int k = 0; k < nq; k++) begin
        beat(ACT_QUERY, $urandom_range(2) ? x0 + 32'($signed($urandom_range(40000)) - 20000)
                                          : coord(),
             $urandom_range(2) ? y0 + 32'($signed($urandom_range(40000)) - 20000) : coord(),
             tol_val());
      end
      items += nv + nq + 1;
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Ran %0d queries (%0d hits) over %0d appends and %0d clears or unused codes,",
             n_query, hits, n_append, n_other);
    $display("with random stalls on both sides and wall thickness from zero to full scale.");
    if (errors == 0 && pending == 0) begin
      $display("[polyline_nearest_station_unit] OK");
    end else begin
      $display("[polyline_nearest_station_unit] ERROR");
    end
    $finish;
  end
endmodule
